[rtl/cctl_pkg.sv]
package cctl_pkg;

  localparam int ROM_SLOTS = 64;
  localparam int IDX_W     = 6;
  localparam int CT_W      = 18;
  localparam int BR_W      = 17;
  localparam int LVL_W     = 16;
  localparam int KELV_W    = 13;
  localparam int WT_W      = 8;
  localparam int DEN_W     = 17;
  localparam int Q_W       = 17;
  localparam int W_W       = 17;
  localparam int BLEND_W   = 24;
  localparam int SB_W      = BLEND_W + BR_W;
  localparam int P_W       = SB_W + LVL_W;
  localparam int Z_W       = 25;
  localparam int QE_W      = 18;

  localparam logic [BR_W-1:0]  BR_FULL   = 17'h10000;
  localparam logic [W_W-1:0]   W_ONE     = 17'h10000;
  localparam logic [LVL_W-1:0] LVL_RESET = 16'hFFFF;

  localparam logic [KELV_W-1:0] CCT_ROM [ROM_SLOTS] = '{
    13'd6050, 13'd5892, 13'd5745, 13'd5620, 13'd5505, 13'd5393, 13'd5307, 13'd5220,
    13'd5136, 13'd5063, 13'd4992, 13'd4922, 13'd4892, 13'd4839, 13'd4827, 13'd4795,
    13'd4762, 13'd4728, 13'd4693, 13'd4656, 13'd4615, 13'd4574, 13'd4528, 13'd4482,
    13'd4436, 13'd4385, 13'd4320, 13'd4272, 13'd4210, 13'd4144, 13'd4075, 13'd3999,
    13'd3915, 13'd3830, 13'd3735, 13'd3630, 13'd3520, 13'd3394, 13'd3260, 13'd3165,
    13'd3165, 13'd3165, 13'd3165, 13'd3165, 13'd3165, 13'd3165, 13'd3165, 13'd3165,
    13'd3165, 13'd3165, 13'd3165, 13'd3165, 13'd3165, 13'd3165, 13'd3165, 13'd3165,
    13'd3165, 13'd3165, 13'd3165, 13'd3165, 13'd3165, 13'd3165, 13'd3165, 13'd3165
  };

  localparam logic [WT_W-1:0] WARM_ROM [ROM_SLOTS] = '{
    8'd0,   8'd20,  8'd40,  8'd60,  8'd80,  8'd100, 8'd120, 8'd140,
    8'd160, 8'd180, 8'd200, 8'd220, 8'd240, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
  };

  localparam logic [WT_W-1:0] COOL_ROM [ROM_SLOTS] = '{
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd250, 8'd240,
    8'd230, 8'd220, 8'd210, 8'd200, 8'd190, 8'd180, 8'd170, 8'd160,
    8'd150, 8'd140, 8'd130, 8'd120, 8'd110, 8'd100, 8'd90,  8'd80,
    8'd70,  8'd60,  8'd50,  8'd40,  8'd30,  8'd20,  8'd10,  8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0
  };

  typedef struct packed {
    logic [DEN_W-1:0] r;
    logic [DEN_W-1:0] den;
    logic [WT_W-1:0]  wlo;
    logic [WT_W-1:0]  whi;
    logic [WT_W-1:0]  clo;
    logic [WT_W-1:0]  chi;
    logic [BR_W-1:0]  b;
  } seg_t;

  typedef struct packed {
    logic [Q_W-1:0]  q;
    logic [WT_W-1:0] wlo;
    logic [WT_W-1:0] whi;
    logic [WT_W-1:0] clo;
    logic [WT_W-1:0] chi;
    logic [BR_W-1:0] b;
  } frac_t;

  typedef struct packed {
    logic [LVL_W-1:0] warm;
    logic [LVL_W-1:0] cool;
  } levels_t;

endpackage

[rtl/cctl_ifs.sv]
interface cctl_in_if;
  logic                       valid;
  logic                       ready;
  logic [cctl_pkg::CT_W-1:0]  color_temp;
  logic [cctl_pkg::BR_W-1:0]  brightness;
  modport source (output valid, color_temp, brightness, input ready);
  modport sink (input valid, color_temp, brightness, output ready);
endinterface

interface cctl_out_if;
  logic                        valid;
  logic                        ready;
  logic [cctl_pkg::LVL_W-1:0]  warm_level;
  logic [cctl_pkg::LVL_W-1:0]  cool_level;
  modport source (output valid, warm_level, cool_level, input ready);
  modport sink (input valid, warm_level, cool_level, output ready);
endinterface

interface cctl_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cctl_pkg::LVL_W-1:0]  led_max_level;
  modport source (output valid, led_max_level, input ready);
  modport sink (input valid, led_max_level, output ready);
endinterface

[rtl/cctl_seg.sv]
module cctl_seg #(
  parameter int TABLE_ENTRIES = 40
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [cctl_pkg::CT_W-1:0]  color_temp_i,
  input  logic [cctl_pkg::BR_W-1:0]  brightness_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output cctl_pkg::seg_t             data_o
);

  localparam int N = (TABLE_ENTRIES < 2) ? 2 :
                     ((TABLE_ENTRIES > cctl_pkg::ROM_SLOTS) ? cctl_pkg::ROM_SLOTS : TABLE_ENTRIES);
  localparam logic [cctl_pkg::IDX_W-1:0] LAST = cctl_pkg::IDX_W'(N - 1);
  localparam logic [cctl_pkg::CT_W-1:0] CT_LOW  = {1'b0, cctl_pkg::CCT_ROM[N-1], 4'b0};
  localparam logic [cctl_pkg::CT_W-1:0] CT_HIGH = {1'b0, cctl_pkg::CCT_ROM[0], 4'b0};

  logic [1:0] v_q;
  logic [1:0] en;

  logic [cctl_pkg::CT_W-1:0]  ct_q;
  logic [cctl_pkg::IDX_W-1:0] lo_q, hi_q, lo_d, hi_d;
  logic                       mid_q, mid_d;
  logic [cctl_pkg::BR_W-1:0]  b_q, b_d;
  cctl_pkg::seg_t             seg_q, seg_d;

  assign en[1]   = !v_q[1] || ready_i;
  assign en[0]   = !v_q[0] || en[1];
  assign ready_o = en[0];
  assign valid_o = v_q[1];
  assign data_o  = seg_q;

  // Segment search: the first entry at or below the temperature wins.
  always_comb begin
    lo_d = LAST;
    for (int i = cctl_pkg::ROM_SLOTS - 1; i >= 1; i--) begin
      if (i < N && {1'b0, cctl_pkg::CCT_ROM[i], 4'b0} <= color_temp_i) begin
        lo_d = cctl_pkg::IDX_W'(i);
      end
    end
    hi_d  = lo_d - cctl_pkg::IDX_W'(1);
    mid_d = 1'b1;
    if (color_temp_i <= CT_LOW) begin
      lo_d  = LAST;
      hi_d  = LAST;
      mid_d = 1'b0;
    end else if (color_temp_i >= CT_HIGH) begin
      lo_d  = '0;
      hi_d  = '0;
      mid_d = 1'b0;
    end
    b_d = (brightness_i > cctl_pkg::BR_FULL) ? cctl_pkg::BR_FULL : brightness_i;
  end

  // Outside the table the divider sees a zero numerator, so the fraction is zero.
  always_comb begin
    logic [cctl_pkg::KELV_W-1:0] kl, kh;
    logic [cctl_pkg::CT_W-1:0]   diff;
    kl   = cctl_pkg::CCT_ROM[lo_q];
    kh   = cctl_pkg::CCT_ROM[hi_q];
    diff = ct_q - {1'b0, kl, 4'b0};
    seg_d.wlo = cctl_pkg::WARM_ROM[lo_q];
    seg_d.whi = cctl_pkg::WARM_ROM[hi_q];
    seg_d.clo = cctl_pkg::COOL_ROM[lo_q];
    seg_d.chi = cctl_pkg::COOL_ROM[hi_q];
    seg_d.b   = b_q;
    if (mid_q) begin
      seg_d.r   = diff[cctl_pkg::DEN_W-1:0];
      seg_d.den = {kh - kl, 4'b0};
    end else begin
      seg_d.r   = '0;
      seg_d.den = cctl_pkg::DEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      if (en[1]) v_q[1] <= v_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ct_q  <= color_temp_i;
      lo_q  <= lo_d;
      hi_q  <= hi_d;
      mid_q <= mid_d;
      b_q   <= b_d;
    end
    if (en[1]) seg_q <= seg_d;
  end

endmodule

[rtl/cctl_div.sv]
module cctl_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  cctl_pkg::seg_t  data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output cctl_pkg::frac_t data_o
);

  localparam int K = cctl_pkg::Q_W;

  logic [K-1:0]               v_q;
  logic [K-1:0]               en;
  cctl_pkg::seg_t             s_q [K];
  logic [cctl_pkg::Q_W-1:0]   q_q [K];

  always_comb begin
    en[K-1] = !v_q[K-1] || ready_i;
    for (int k = K - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[K-1];

  always_comb begin
    data_o.q   = q_q[K-1];
    data_o.wlo = s_q[K-1].wlo;
    data_o.whi = s_q[K-1].whi;
    data_o.clo = s_q[K-1].clo;
    data_o.chi = s_q[K-1].chi;
    data_o.b   = s_q[K-1].b;
  end

  // One quotient bit per stage; the remainder always stays below the divisor.
  for (genvar k = 0; k < K; k++) begin : g_stage
    cctl_pkg::seg_t           s_in, s_d;
    logic [cctl_pkg::Q_W-1:0] q_in, q_d;
    logic                     v_in;

    if (k == 0) begin : g_first
      assign s_in = data_i;
      assign q_in = '0;
      assign v_in = valid_i;
    end else begin : g_next
      assign s_in = s_q[k-1];
      assign q_in = q_q[k-1];
      assign v_in = v_q[k-1];
    end

    always_comb begin
      logic [cctl_pkg::DEN_W:0] r2, sub;
      logic                     ge;
      r2  = {s_in.r, 1'b0};
      sub = r2 - {1'b0, s_in.den};
      ge  = r2 >= {1'b0, s_in.den};
      s_d   = s_in;
      s_d.r = ge ? sub[cctl_pkg::DEN_W-1:0] : r2[cctl_pkg::DEN_W-1:0];
      q_d   = {q_in[cctl_pkg::Q_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        s_q[k] <= s_d;
        q_q[k] <= q_d;
      end
    end
  end

endmodule

[rtl/cctl_scale.sv]
module cctl_scale (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  cctl_pkg::frac_t             data_i,
  input  logic [cctl_pkg::LVL_W-1:0]  led_max_level_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output cctl_pkg::levels_t           data_o
);

  localparam int K = 7;
  localparam int S_W = cctl_pkg::WT_W + cctl_pkg::W_W + 1;
  localparam logic [cctl_pkg::P_W:0]    HALF_D = (cctl_pkg::P_W + 1)'(255) << 31;
  localparam logic [cctl_pkg::Z_W-1:0]  DIV_C  = cctl_pkg::Z_W'(255);

  logic [K-1:0] v_q;
  logic [K-1:0] en;

  // Stage 0: rounded fraction and its complement.
  logic [cctl_pkg::W_W-1:0]     w_q, nw_q;
  cctl_pkg::frac_t              f_q;
  // Stages 1 to 3: blended weight, times brightness, times full scale.
  logic [cctl_pkg::BLEND_W-1:0] sw_q, sc_q;
  logic [cctl_pkg::BR_W-1:0]    b1_q;
  logic [cctl_pkg::SB_W-1:0]    bw_q, bc_q;
  logic [cctl_pkg::P_W-1:0]     pw_q, pc_q;
  // Stages 4 to 6: drop 2^32 with rounding, then divide by 255.
  logic [cctl_pkg::Z_W-1:0]     zw_q, zc_q, zw5_q, zc5_q;
  logic [cctl_pkg::QE_W-1:0]    ew_q, ec_q;
  cctl_pkg::levels_t            lv_q;

  always_comb begin
    en[K-1] = !v_q[K-1] || ready_i;
    for (int k = K - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[K-1];
  assign data_o  = lv_q;

  function automatic logic [cctl_pkg::BLEND_W-1:0] blend(
    input logic [cctl_pkg::WT_W-1:0] lo,
    input logic [cctl_pkg::WT_W-1:0] hi,
    input logic [cctl_pkg::W_W-1:0]  nw,
    input logic [cctl_pkg::W_W-1:0]  w
  );
    logic [S_W-1:0] s;
    s = S_W'(lo) * S_W'(nw) + S_W'(hi) * S_W'(w);
    return s[cctl_pkg::BLEND_W-1:0];
  endfunction

  function automatic logic [cctl_pkg::Z_W-1:0] round_top(input logic [cctl_pkg::P_W-1:0] p);
    logic [cctl_pkg::P_W:0] s;
    s = {1'b0, p} + HALF_D;
    return s[32 +: cctl_pkg::Z_W];
  endfunction

  // Estimate of z/255 from the reciprocal 0x01010101 / 2^32; it is low by at most one.
  function automatic logic [cctl_pkg::QE_W-1:0] est255(input logic [cctl_pkg::Z_W-1:0] z);
    logic [cctl_pkg::Z_W+25:0] s;
    s = {26'b0, z} + ({26'b0, z} << 8) + ({26'b0, z} << 16) + ({26'b0, z} << 24);
    return s[32 +: cctl_pkg::QE_W];
  endfunction

  function automatic logic [cctl_pkg::LVL_W-1:0] fix255(
    input logic [cctl_pkg::Z_W-1:0]  z,
    input logic [cctl_pkg::QE_W-1:0] qe
  );
    logic [cctl_pkg::Z_W-1:0]  m, r;
    logic [cctl_pkg::QE_W-1:0] q;
    m = (cctl_pkg::Z_W'(qe) << 8) - cctl_pkg::Z_W'(qe);
    r = z - m;
    q = (r >= DIV_C) ? qe + cctl_pkg::QE_W'(1) : qe;
    return q[cctl_pkg::LVL_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < K; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      logic [cctl_pkg::Q_W:0] qr;
      qr   = {1'b0, data_i.q} + (cctl_pkg::Q_W + 1)'(1);
      w_q  <= qr[cctl_pkg::Q_W:1];
      nw_q <= cctl_pkg::W_ONE - qr[cctl_pkg::Q_W:1];
      f_q  <= data_i;
    end
    if (en[1]) begin
      sw_q <= blend(f_q.wlo, f_q.whi, nw_q, w_q);
      sc_q <= blend(f_q.clo, f_q.chi, nw_q, w_q);
      b1_q <= f_q.b;
    end
    if (en[2]) begin
      bw_q <= sw_q * b1_q;
      bc_q <= sc_q * b1_q;
    end
    if (en[3]) begin
      pw_q <= bw_q * led_max_level_i;
      pc_q <= bc_q * led_max_level_i;
    end
    if (en[4]) begin
      zw_q <= round_top(pw_q);
      zc_q <= round_top(pc_q);
    end
    if (en[5]) begin
      ew_q  <= est255(zw_q);
      ec_q  <= est255(zc_q);
      zw5_q <= zw_q;
      zc5_q <= zc_q;
    end
    if (en[6]) begin
      lv_q.warm <= fix255(zw5_q, ew_q);
      lv_q.cool <= fix255(zc5_q, ec_q);
    end
  end

endmodule

[rtl/cct_to_warm_cool_led_levels.sv]
// Colour temperature to warm/cool LED drive levels.
//
// in_ch carries color_temp (Kelvin, 4 fraction bits) and brightness (Q1.16);
// a transaction completes when valid and ready are both high. out_ch returns
// one transaction per input with warm_level and cool_level. cfg_ch writes the
// full-scale level led_max_level; it is always ready, and the user must write it
// only while no item is in flight; the block itself does not enforce this.
//
// From input transaction to output valid, an item passes through table search
// and segment setup, bit-per-stage fraction division, and then blending,
// scaling and division by 255. Throughput is one item per cycle while out_ch
// is ready; every stage has its own valid bit.
//
// Reset clears all valid bits and sets led_max_level to 65535. When the
// receiver stalls, the stalled output holds, and earlier stages keep filling
// any empty slots, so input is taken until the pipeline is full.
module cct_to_warm_cool_led_levels #(
  parameter int TABLE_ENTRIES = 40
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cctl_in_if.sink    in_ch,
  cctl_out_if.source out_ch,
  cctl_cfg_if.sink   cfg_ch
);

  logic [cctl_pkg::LVL_W-1:0] led_max_level_q;

  logic              seg_valid, seg_ready;
  cctl_pkg::seg_t    seg_data;
  logic              div_valid, div_ready;
  cctl_pkg::frac_t   div_data;
  cctl_pkg::levels_t lv_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_max_level_q <= cctl_pkg::LVL_RESET;
    end else if (cfg_ch.valid) begin
      led_max_level_q <= cfg_ch.led_max_level;
    end
  end

  cctl_seg #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_seg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_ch.valid),
    .ready_o     (in_ch.ready),
    .color_temp_i(in_ch.color_temp),
    .brightness_i(in_ch.brightness),
    .valid_o     (seg_valid),
    .ready_i     (seg_ready),
    .data_o      (seg_data)
  );

  cctl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(seg_valid),
    .ready_o(seg_ready),
    .data_i (seg_data),
    .valid_o(div_valid),
    .ready_i(div_ready),
    .data_o (div_data)
  );

  cctl_scale u_scale (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (div_valid),
    .ready_o        (div_ready),
    .data_i         (div_data),
    .led_max_level_i(led_max_level_q),
    .valid_o        (out_ch.valid),
    .ready_i        (out_ch.ready),
    .data_o         (lv_data)
  );

  assign out_ch.warm_level = lv_data.warm;
  assign out_ch.cool_level = lv_data.cool;

endmodule

[rtl/cctl_chk.sv]
module cctl_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [cctl_pkg::LVL_W-1:0] warm_level_i,
  input logic [cctl_pkg::LVL_W-1:0] cool_level_i,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_i
);

  // A stalled result must hold until the receiver takes it.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(warm_level_i)
                                    && $stable(cool_level_i))
    else $error("output transaction changed while stalled");

  // With the receiver ready, no stage can be blocked, so input is taken.
  a_flow: assert property (@(posedge clk_i) out_ready_i |-> in_ready_i)
    else $error("input stalled although output is ready");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("output valid during reset");

  // The register port never back-pressures.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("configuration transaction refused");

endmodule

bind cct_to_warm_cool_led_levels cctl_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .warm_level_i(out_ch.warm_level),
  .cool_level_i(out_ch.cool_level),
  .cfg_valid_i (cfg_ch.valid),
  .cfg_ready_i (cfg_ch.ready)
);

[dv/cctl_checker.sv]
module cctl_checker #(
  parameter int TABLE_ENTRIES = 40
) (
  input  logic clk_i,
  input  logic rst_ni,
  cctl_in_if.sink    in_mon,
  cctl_out_if.sink   out_mon,
  cctl_cfg_if.sink   cfg_mon,
  output int         fail_count_o,
  output int         pending_o
);
  import cctl_pkg::*;

  logic [LVL_W-1:0] max_level;
  levels_t          levels_q[$];

  assign pending_o = levels_q.size();

  function automatic logic [LVL_W-1:0] scale_weight(logic [63:0] blended,
                                                    logic [63:0] bright,
                                                    logic [63:0] lmax);
    logic [63:0] d;
    logic [63:0] p;
    d = 64'd255 << 32;
    p = blended * bright * lmax;
    return LVL_W'((p + (d >> 1)) / d);
  endfunction

  function automatic levels_t predict_levels(logic [CT_W-1:0] ct, logic [BR_W-1:0] br,
                                             logic [LVL_W-1:0] lmax);
    int          n;
    int          lo;
    int          hi;
    logic [63:0] w;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] b;
    logic [63:0] warm;
    logic [63:0] cool;
    levels_t     r;
    n = TABLE_ENTRIES < 2 ? 2 : (TABLE_ENTRIES > ROM_SLOTS ? ROM_SLOTS : TABLE_ENTRIES);
    b = (br > BR_FULL) ? 64'(BR_FULL) : 64'(br);
    w = 0;
    lo = n - 1;
    hi = n - 1;
    if (64'(ct) <= (64'(CCT_ROM[n-1]) << 4)) begin
      lo = n - 1;
    end else if (64'(ct) >= (64'(CCT_ROM[0]) << 4)) begin
      lo = 0;
      hi = 0;
    end else begin
      for (int i = n - 1; i >= 1; i--) begin
        if ((64'(CCT_ROM[i]) << 4) <= 64'(ct)) lo = i;
      end
      hi = lo - 1;
      num = 64'(ct) - (64'(CCT_ROM[lo]) << 4);
      den = (64'(CCT_ROM[hi]) - 64'(CCT_ROM[lo])) << 4;
      if (den != 0) begin
        w = ((num << 17) + den) / (den << 1);
        if (w > 64'd65536) w = 64'd65536;
      end
    end
    warm = 64'(WARM_ROM[lo]) * (64'd65536 - w) + 64'(WARM_ROM[hi]) * w;
    cool = 64'(COOL_ROM[lo]) * (64'd65536 - w) + 64'(COOL_ROM[hi]) * w;
    r.warm = scale_weight(warm, b, 64'(lmax));
    r.cool = scale_weight(cool, b, 64'(lmax));
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    levels_t exp_lv;
    if (!rst_ni) begin
      max_level <= LVL_RESET;
      fail_count_o <= 0;
      levels_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        levels_q.push_back(predict_levels(in_mon.color_temp, in_mon.brightness, max_level));
      end
      if (cfg_mon.valid && cfg_mon.ready) max_level <= cfg_mon.led_max_level;
      if (out_mon.valid && out_mon.ready) begin
        if (levels_q.size() == 0) begin
          $error("unexpected result transaction warm=%0d cool=%0d",
                 out_mon.warm_level, out_mon.cool_level);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_lv = levels_q.pop_front();
          if (out_mon.warm_level !== exp_lv.warm ||
              out_mon.cool_level !== exp_lv.cool) begin
            fail_count_o <= fail_count_o + 1;
            if (out_mon.warm_level !== exp_lv.warm)
              $error("warm_level expected %0d actual %0d", exp_lv.warm, out_mon.warm_level);
            if (out_mon.cool_level !== exp_lv.cool)
              $error("cool_level expected %0d actual %0d", exp_lv.cool, out_mon.cool_level);
          end
        end
      end
    end
  end
endmodule

[dv/tb_cct_to_warm_cool_led_levels.sv]
module tb_cct_to_warm_cool_led_levels;

  localparam int LATENCY = 26;
  localparam int CYCLE_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  bit   busy_in = 1'b1;
  bit   calm = 1'b0;

  cctl_in_if  in_ch();
  cctl_out_if out_ch();
  cctl_cfg_if cfg_ch();

  always #2 clk_i = ~clk_i;

  cct_to_warm_cool_led_levels dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  cctl_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.color_temp = '0;
    in_ch.brightness = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.led_max_level = '0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL cct_to_warm_cool_led_levels");
      $finish;
    end
  end

  // The receiver stalls at random except during the calm stretch.
  always @(negedge clk_i) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 23);
  end

  // Valid stays high after a transaction so that items can follow back to back;
  // the caller drops it once a burst is done.
  task automatic send_item(logic [cctl_pkg::CT_W-1:0] ct, logic [cctl_pkg::BR_W-1:0] br);
    while (!calm && $urandom_range(99) < 23) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.color_temp <= ct;
    in_ch.brightness <= br;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_max_level(logic [cctl_pkg::LVL_W-1:0] lvl);
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.led_max_level <= lvl;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly in-table temperatures and sane brightness, with full-range noise.
  task automatic send_random(int count);
    logic [cctl_pkg::CT_W-1:0] ct;
    logic [cctl_pkg::BR_W-1:0] br;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: ct = cctl_pkg::CT_W'($urandom);
        1: ct = cctl_pkg::CT_W'(cctl_pkg::CCT_ROM[$urandom_range(39)]) << 4;
        default: ct = cctl_pkg::CT_W'($urandom_range(6050 * 16, 3165 * 16));
      endcase
      br = ($urandom_range(4) == 0) ? cctl_pkg::BR_W'($urandom)
                                    : cctl_pkg::BR_W'($urandom_range(65536));
      send_item(ct, br);
    end
  endtask

  initial begin
    logic [cctl_pkg::LVL_W-1:0] levels[5];
    levels = '{16'hFFFF, 16'd0, 16'd1, 16'd1000, 16'h8000};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_item('0, '0);
    send_item('1, '1);
    send_item(18'd3165 << 4, 17'h10000);
    send_item((18'd3165 << 4) + 1, 17'h10000);
    send_item(18'd6050 << 4, 17'h10000);
    send_item((18'd6050 << 4) - 1, 17'hFFFF);
    send_item(18'd6050 << 4 | 18'd1, 17'h10001);
    send_item(18'd4827 << 4, 17'd32768);
    send_item((18'd4839 << 4) - 1, 17'd1);
    send_item(18'h2AAAA, 17'h15555);
    send_item(18'h15555, 17'h0AAAA);
    send_item(18'd4500 << 4 | 18'd8, 17'h1FFFF);
    in_ch.valid <= 1'b0;
    for (int k = 0; k < 5; k++) begin
      write_max_level(levels[k]);
      calm = (k == 2);
      send_random(k == 0 ? 1000 : 210);
      in_ch.valid <= 1'b0;
      calm = 1'b0;
    end
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS cct_to_warm_cool_led_levels");
    end else begin
      $display("FAIL cct_to_warm_cool_led_levels");
    end
    $finish;
  end
endmodule
